// ===== src/utf16_to_utf8_encoder_assert.svh =====
// assertion macros used by the checker file
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define UTFENC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define UTFENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/utfenc_pkg.sv =====
// shared types, constants and the utf-8 byte encoder
package utfenc_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_BUFFER_SIZE = 3'd0;

    localparam logic [15:0] BUFFER_SIZE_RESET = 16'hFFFF;
    localparam logic [20:0] CP_REPLACEMENT    = 21'h00FFFD;
    localparam logic [20:0] CP_SUPPLEMENTARY  = 21'h010000;
    localparam logic [20:0] CP_LIMIT_1BYTE    = 21'h000080;
    localparam logic [20:0] CP_LIMIT_2BYTE    = 21'h000800;
    localparam logic [23:0] REPLACEMENT_BYTES = 24'hEFBFBD;
    localparam logic [2:0]  REPLACEMENT_LEN   = 3'd3;

    // one utf-8 sequence, first byte in the top bits
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] bytes;
    } t_enc;

    // work handed from the front to the back
    typedef struct packed {
        logic        rep_first;  // a broken surrogate's U+FFFD goes first
        logic [2:0]  main_len;   // zero when the word yields no own code point
        logic [31:0] main_bytes;
        logic        eot;
    } t_entry;

    function automatic t_enc encode(input logic [20:0] cp);
        t_enc e;
        e.len   = 3'd0;
        e.bytes = 32'h0;
        if (cp < CP_LIMIT_1BYTE) begin
            e.len   = 3'd1;
            e.bytes = {1'b0, cp[6:0], 24'h0};
        end else if (cp < CP_LIMIT_2BYTE) begin
            e.len   = 3'd2;
            e.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
        end else if (cp < CP_SUPPLEMENTARY) begin
            e.len   = 3'd3;
            e.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
        end else begin
            e.len   = 3'd4;
            e.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== src/utfenc_front.sv =====
// front: takes utf-16 words, pairs surrogates and encodes code points
module utfenc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_code_unit,
    input  logic                 i_end_of_text,
    output logic                 o_push,
    output utfenc_pkg::t_entry   o_entry,
    input  logic                 i_push_ready
);
    import utfenc_pkg::*;

    logic       r_high_pending, n_high_pending;
    logic [9:0] r_high_bits, n_high_bits;
    logic       is_high, is_low, accept;
    logic [20:0] main_cp, pair_cp;
    logic       main_on;
    t_enc       enc;

    assign accept  = i_valid && i_push_ready;
    assign o_ready = i_push_ready;

    always_comb begin
        is_high = i_code_unit inside {[16'hD800:16'hDBFF]};
        is_low  = i_code_unit inside {[16'hDC00:16'hDFFF]};
        pair_cp = CP_SUPPLEMENTARY + {1'b0, r_high_bits, 10'h0}
                + {11'h0, i_code_unit[9:0]};
        main_on = 1'b1;
        main_cp = {5'h0, i_code_unit};
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        if (r_high_pending && is_low) begin
            main_cp = pair_cp;
        end else if (is_high) begin
            // a high surrogate waits for its partner unless the text ends here
            main_on = i_end_of_text;
            main_cp = CP_REPLACEMENT;
        end else if (is_low) begin
            main_cp = CP_REPLACEMENT;
        end
        enc = encode(main_cp);

        o_entry.rep_first  = r_high_pending && !is_low;
        o_entry.main_len   = main_on ? enc.len : 3'd0;
        o_entry.main_bytes = enc.bytes;
        o_entry.eot        = i_end_of_text;
        o_push = accept && (o_entry.rep_first || main_on || i_end_of_text);

        if (accept) begin
            if (i_end_of_text) begin
                n_high_pending = 1'b0;
                n_high_bits    = 10'h0;
            end else if (is_high && !(r_high_pending && is_low)) begin
                n_high_pending = 1'b1;
                n_high_bits    = i_code_unit[9:0];
            end else begin
                n_high_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_high_bits    <= 10'h0;
        end else begin
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
        end
    end

endmodule

// ===== src/utfenc_queue.sv =====
// two-entry queue between front and back
module utfenc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utfenc_pkg::t_entry   i_entry,
    output logic                 o_push_ready,
    output logic                 o_valid,
    output utfenc_pkg::t_entry   o_entry,
    input  logic                 i_pop
);
    import utfenc_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_entry      = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== src/utfenc_back.sv =====
// back: fit check against the buffer, then one byte per cycle out while the output is not stalled
module utfenc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_buffer_size,
    input  logic                 i_q_valid,
    input  utfenc_pkg::t_entry   i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_run_last,
    output logic                 o_string_done,
    output logic [15:0]          o_total_bytes
);
    import utfenc_pkg::*;

    // committed string state
    logic [15:0] r_bw, n_bw;
    logic        r_stopped, n_stopped;
    // word being sent
    logic [47:0] r_buf, n_buf;
    logic [2:0]  r_left, n_left;
    logic        r_eot, n_eot;
    logic        r_bare, n_bare;
    logic [15:0] r_tot, n_tot;
    // output register
    logic        r_ov, n_ov;
    logic [7:0]  r_byte, n_byte;
    logic        r_bval, n_bval;
    logic        r_rlast, n_rlast;
    logic        r_done, n_done;
    logic [15:0] r_total, n_total;

    logic        step, load;
    logic [15:0] usable;
    logic [16:0] room;
    logic        fit_rep, stop_rep, fit_main, main_on;
    logic [2:0]  rep_len, main_need, n_bytes;
    logic [31:0] main_sel;
    logic [15:0] tot_step;

    assign step    = (r_left != 3'd0) && (!r_ov || i_ready);
    assign load    = i_q_valid && ((r_left == 3'd0) || ((r_left == 3'd1) && step));
    assign o_q_pop = load;

    always_comb begin
        usable    = (i_buffer_size == 16'h0) ? 16'h0 : i_buffer_size - 16'h1;
        // signed space left; negative once the size shrank below the count
        room      = {1'b0, usable} - {1'b0, r_bw};
        main_on   = (i_q_entry.main_len != 3'd0);
        fit_rep   = i_q_entry.rep_first && !r_stopped && !room[16]
                  && (room[15:0] >= {13'h0, REPLACEMENT_LEN});
        stop_rep  = r_stopped || (i_q_entry.rep_first && !fit_rep);
        rep_len   = fit_rep ? REPLACEMENT_LEN : 3'd0;
        main_need = rep_len + i_q_entry.main_len;
        fit_main  = main_on && !stop_rep && !room[16]
                  && (room[15:0] >= {13'h0, main_need});
        main_sel  = fit_main ? i_q_entry.main_bytes : 32'h0;
        n_bytes   = fit_main ? main_need : rep_len;
        tot_step  = r_bare ? r_tot : r_tot + 16'h1;

        n_bw      = r_bw;
        n_stopped = r_stopped;
        n_buf     = r_buf;
        n_left    = r_left;
        n_eot     = r_eot;
        n_bare    = r_bare;
        n_tot     = r_tot;
        n_ov      = r_ov && !i_ready;
        n_byte    = r_byte;
        n_bval    = r_bval;
        n_rlast   = r_rlast;
        n_done    = r_done;
        n_total   = r_total;

        if (step) begin
            n_ov    = 1'b1;
            n_byte  = r_buf[47:40];
            n_bval  = !r_bare;
            n_rlast = (r_left == 3'd1);
            n_done  = (r_left == 3'd1) && r_eot;
            n_total = tot_step;
            n_tot   = tot_step;
            n_buf   = {r_buf[39:0], 8'h0};
            n_left  = r_left - 3'd1;
        end

        if (load) begin
            n_buf  = fit_rep ? {REPLACEMENT_BYTES, main_sel[31:8]} : {main_sel, 16'h0};
            n_eot  = i_q_entry.eot;
            n_tot  = r_bw;
            // an end with nothing written still gives one bare marker
            n_bare = i_q_entry.eot && (n_bytes == 3'd0);
            n_left = n_bare ? 3'd1 : n_bytes;
            if (i_q_entry.eot) begin
                n_bw      = 16'h0;
                n_stopped = 1'b0;
            end else begin
                n_bw      = r_bw + {13'h0, n_bytes};
                n_stopped = stop_rep || (main_on && !fit_main);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf   <= n_buf;
        r_tot   <= n_tot;
        r_byte  <= n_byte;
        r_bval  <= n_bval;
        r_rlast <= n_rlast;
        r_done  <= n_done;
        r_total <= n_total;
        r_eot   <= n_eot;
        r_bare  <= n_bare;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw      <= 16'h0;
            r_stopped <= 1'b0;
            r_left    <= 3'd0;
            r_ov      <= 1'b0;
        end else begin
            r_bw      <= n_bw;
            r_stopped <= n_stopped;
            r_left    <= n_left;
            r_ov      <= n_ov;
        end
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bval;
    assign o_run_last    = r_rlast;
    assign o_string_done = r_done;
    assign o_total_bytes = r_total;

endmodule

// ===== src/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder with a bounded output count. Each input word is
// one UTF-16 code unit; each output word is one UTF-8 byte with its running
// count, or a bare end marker when the last unit of a string writes nothing.
// A word yields up to 6 output bytes; a high surrogate waiting for its
// partner yields none. The front classifies a unit per cycle into a
// two-entry queue unless it is full, and the back drains one byte per cycle
// unless the output stalls. Sequences are written whole or dropped; the
// first one that does not fit in buffer_size - 1 bytes stops output until
// the string ends. buffer_size is an APB register at byte address 0 (reset
// 65535); the user writes it only while idle; the block does not check.
module utf16_to_utf8_encoder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [15:0]                            i_code_unit,
    input  logic                                   i_end_of_text,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_byte_valid,
    output logic                                   o_run_last,
    output logic                                   o_string_done,
    output logic [15:0]                            o_total_bytes,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [utfenc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [utfenc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [utfenc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                   pready
);
    import utfenc_pkg::*;

    logic [15:0] r_buffer_size;
    logic        reg_hit;
    logic        f_push, q_push_ready, q_valid, q_pop;
    t_entry      f_entry, q_entry;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == ADDR_BUFFER_SIZE[APB_ADDR_W-1:2]);
    assign prdata  = reg_hit ? {{(APB_DATA_W-16){1'b0}}, r_buffer_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_buffer_size <= pwdata[15:0];
        end
    end

    utfenc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .o_push        (f_push),
        .o_entry       (f_entry),
        .i_push_ready  (q_push_ready)
    );

    utfenc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .i_entry      (f_entry),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_entry      (q_entry),
        .i_pop        (q_pop)
    );

    utfenc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_buffer_size (r_buffer_size),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_total_bytes (o_total_bytes)
    );

endmodule

// ===== src/utfenc_checker.sv =====
// port-level checks on the encoder, bound to the top level
`include "utf16_to_utf8_encoder_assert.svh"

module utfenc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic [7:0]                             o_out_byte,
    input logic                                   o_byte_valid,
    input logic                                   o_run_last,
    input logic                                   o_string_done,
    input logic [15:0]                            o_total_bytes
);

    // a stalled output word holds
    `UTFENC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte) && $stable(o_total_bytes) && $stable(o_string_done), "output word changed while stalled")

    // a bare marker only closes a string
    `UTFENC_ASSERT_NOW(a_bare_is_end, i_clk, i_rst_n, o_valid && !o_byte_valid, o_string_done && o_run_last && (o_out_byte == 8'h00), "bare marker outside string end")

    // the string end is always the last word of its unit
    `UTFENC_ASSERT_NOW(a_done_last, i_clk, i_rst_n, o_valid && o_string_done, o_run_last, "string end without run end")

    // a written byte is counted
    `UTFENC_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, o_valid && o_byte_valid, o_total_bytes != 16'h0, "byte with zero running count")

endmodule

bind utf16_to_utf8_encoder utfenc_checker u_utfenc_checker (.*);
